/* rtl/core/nvts_pkg.sv */
// Shared types and constants for the nearest-value take store.
// No dependencies; imported by the top level.
package nvts_pkg;

   localparam int ENTRIES = 256;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int VAL_W   = 31;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_TAKE   = 1'b1;

   localparam logic [1:0] ST_EXISTS = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_TAKEN  = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   typedef struct packed {
      logic             action;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [VAL_W-1:0] taken_value;
   } rsp_type;

endpackage

/* rtl/core/nearest_value_take_store_top.sv */
// Top level of the nearest-value take store: slot memory, valid bits and scan sequencer.
// Depends on nvts_pkg for the payload types, status codes and table size.
//
//   channel | direction | ports                          | payload
//   req     | in        | req_valid, req_ready, req_data | action, value
//   rsp     | out       | rsp_valid, rsp_ready, rsp_data | status, taken_value
//
// Every item scans all ENTRIES slots, one memory read per cycle, through a
// three-stage read, distance and compare pipeline: the sequencer runs S_SCAN,
// S_DRAIN and S_FINISH, the result is registered as it leaves S_FINISH, and
// req_ready returns in the same cycle. req_ready is high only while idle.
// A finished result waits in the output register; the next item finishes only
// after that result has been transferred. Reset clears all valid bits at once.
module nearest_value_take_store_top
   import nvts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DRAIN  = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               act_ff;
   logic [VAL_W-1:0]   query_ff;

   logic [VAL_W-1:0]   slot_mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;

   logic               s1_ff, s2_ff;
   logic [VAL_W-1:0]   rd_data_ff;
   logic               rd_vld_ff;
   logic [IDX_W-1:0]   rd_slot_ff;

   logic [VAL_W-1:0]   val2_ff;
   logic [VAL_W-1:0]   dist2_ff;
   logic               vld2_ff;
   logic [IDX_W-1:0]   slot2_ff;

   logic               have_best_ff;
   logic [VAL_W-1:0]   best_val_ff;
   logic [VAL_W-1:0]   best_dist_ff;
   logic [IDX_W-1:0]   best_slot_ff;
   logic               found_ff;
   logic               have_free_ff;
   logic [IDX_W-1:0]   free_slot_ff;

   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic               req_xfer;
   logic               out_free;
   logic               finish_go;
   logic               mem_wr;
   logic               better;
   logic [VAL_W-1:0]   dist_calc;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign finish_go = (state_ff == S_FINISH) && out_free;
   assign mem_wr    = finish_go && (act_ff == ACT_INSERT) && !found_ff && have_free_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (req_xfer) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!s1_ff && !s2_ff) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         act_ff   <= req_data.action;
         query_ff <= req_data.value;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         slot_mem[free_slot_ff] <= query_ff;
      end
      rd_data_ff <= slot_mem[idx_ff];
      rd_vld_ff  <= valid_ff[idx_ff];
      rd_slot_ff <= idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (finish_go) begin
         if (mem_wr) begin
            valid_ff[free_slot_ff] <= 1'b1;
         end else if ((act_ff == ACT_TAKE) && have_best_ff) begin
            valid_ff[best_slot_ff] <= 1'b0;
         end
      end
   end

   assign dist_calc = (rd_data_ff >= query_ff) ? (rd_data_ff - query_ff)
                                                : (query_ff - rd_data_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
      end else begin
         s1_ff <= (state_ff == S_SCAN);
         s2_ff <= s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      val2_ff  <= rd_data_ff;
      dist2_ff <= dist_calc;
      vld2_ff  <= rd_vld_ff;
      slot2_ff <= rd_slot_ff;
   end

   assign better = !have_best_ff || (dist2_ff < best_dist_ff) ||
                   ((dist2_ff == best_dist_ff) && (val2_ff < best_val_ff));

   always_ff @(posedge clock) begin
      if (reset || req_xfer) begin
         have_best_ff <= 1'b0;
         found_ff     <= 1'b0;
         have_free_ff <= 1'b0;
      end else if (s2_ff) begin
         if (vld2_ff) begin
            if (dist2_ff == '0) begin
               found_ff <= 1'b1;
            end
            if (better) begin
               have_best_ff <= 1'b1;
            end
         end else begin
            have_free_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ff) begin
         if (vld2_ff && better) begin
            best_val_ff  <= val2_ff;
            best_dist_ff <= dist2_ff;
            best_slot_ff <= slot2_ff;
         end
         if (!vld2_ff && !have_free_ff) begin
            free_slot_ff <= slot2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish_go) begin
         rsp_valid_ff <= (act_ff == ACT_TAKE) || found_ff || !have_free_ff;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_go) begin
         rsp_data_ff.taken_value <= '0;
         if (act_ff == ACT_TAKE) begin
            if (have_best_ff) begin
               rsp_data_ff.status      <= ST_TAKEN;
               rsp_data_ff.taken_value <= best_val_ff;
            end else begin
               rsp_data_ff.status <= ST_EMPTY;
            end
         end else if (found_ff) begin
            rsp_data_ff.status <= ST_EXISTS;
         end else begin
            rsp_data_ff.status <= ST_FULL;
         end
      end
   end

endmodule
